// ----- hdl/lpc_pkg.sv -----
// shared types, constants and blend arithmetic for the layer pixel compositor
package lpc_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_MULTIPLY = 2'd1,
      MODE_ADD      = 2'd2,
      MODE_REPLACE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] pixel_index;
      logic        first_layer;
      mode_type    blend_mode;
      logic [7:0]  opacity;
      logic [7:0]  src_red;
      logic [7:0]  src_green;
      logic [7:0]  src_blue;
      logic [7:0]  src_alpha;
   } req_type;

   typedef struct packed {
      logic [15:0] out_index;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [7:0]  out_alpha;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      req_type     req;
      logic [15:0] alpha_prod;
   } work_type;

   localparam int          QUEUE_DEPTH   = 4;
   localparam int          CHANNELS      = 4;
   localparam logic [15:0] FULL_SQ       = 16'd65025;
   localparam logic [16:0] FULL_SQ_RECIP = 17'd66051;
   localparam logic [7:0]  CHAN_MAX      = 8'd255;

   // numerator over 65025 for a color channel
   function automatic logic [23:0] chan_num(mode_type mode, logic [7:0] s, logic [7:0] d,
                                            logic [15:0] p);
      logic [15:0] x;
      logic [7:0]  y;
      logic [15:0] w;
      if (mode == MODE_NORMAL) begin
         x = p;
         y = s;
         w = FULL_SQ - p;
      end else begin
         // s*d/255 == s*255*d/65025
         x = {s, 8'd0} - {8'd0, s};
         y = d;
         w = 16'd0;
      end
      return (24'(x) * 24'(y)) + (24'(w) * 24'(d));
   endfunction

   // numerator over 65025 for the alpha channel
   function automatic logic [23:0] alpha_num(mode_type mode, logic [7:0] da, logic [15:0] p);
      logic [7:0]  y;
      logic [15:0] w;
      y = (mode == MODE_MULTIPLY) ? da : CHAN_MAX;
      w = (mode == MODE_NORMAL) ? (FULL_SQ - p) : 16'd0;
      return (24'(p) * 24'(y)) + (24'(w) * 24'(da));
   endfunction

   // reciprocal estimate of num/65025, low by at most one
   function automatic logic [7:0] div_est(logic [23:0] num);
      logic [40:0] prod;
      prod = 41'(num) * 41'(FULL_SQ_RECIP);
      return prod[39:32];
   endfunction

   // one correction step, q*65025 built from shifts
   function automatic logic [7:0] div_fix(logic [23:0] num, logic [7:0] est);
      logic [23:0] back;
      logic [23:0] rem;
      back = {est, 16'd0} - {7'd0, est, 9'd0} + 24'(est);
      rem  = num - back;
      return (rem >= 24'(FULL_SQ)) ? (est + 8'd1) : est;
   endfunction

   function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[8] ? CHAN_MAX : sum[7:0];
   endfunction

   function automatic logic [7:0] chan_result(mode_type mode, logic [7:0] q, logic [7:0] s,
                                              logic [7:0] d);
      logic [7:0] r;
      case (mode)
         MODE_ADD:     r = sat_add(s, d);
         MODE_REPLACE: r = s;
         default:      r = q;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] alpha_result(mode_type mode, logic [7:0] q, logic [7:0] da);
      logic [7:0] r;
      case (mode)
         MODE_ADD: r = sat_add(q, da);
         default:  r = q;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/layer_pixel_compositor_core.sv -----
// layer pixel compositor top level: blends layer pixels into an rgba8 accumulation buffer
// input queue side: push a layer pixel on req_data while full is low; each transaction
//   reads the stored pixel (or zero on a first layer), blends it and writes it back
// result queue side: while empty is low the oldest blended pixel sits on rsp_data,
//   pop takes it
// path: a result becomes visible after its input transaction has passed two front
//   stages, the classify queue, three read-modify-write stages and the result queue
// throughput: one pixel per cycle for distinct pixels while the result queue has room;
//   the buffer loop is three stages from memory read to write-back; a pixel repeating
//   one of the two items just ahead waits, the write of the third one back is forwarded
// reset: clears both queues and all stage valids; the buffer itself is not cleared and
//   holds no meaningful data until a first-layer pixel writes it
// stall: a full result queue (4 entries) freezes the back end, the classify queue
//   (4 entries) then fills and raises full toward the producer
module layer_pixel_compositor_core #(
   parameter int PIXELS = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  lpc_pkg::req_type   req_data,
   output logic               empty,
   input  logic               pop,
   output lpc_pkg::rsp_type   rsp_data
);

   localparam int SLOT_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int WORK_W = $bits(lpc_pkg::work_type);
   localparam int MID_W  = WORK_W + SLOT_W;
   localparam int RSP_W  = $bits(lpc_pkg::rsp_type);

   // front to classify queue
   logic                mid_push, mid_full, mid_empty;
   lpc_pkg::work_type   front_work;
   logic [SLOT_W-1:0]   front_slot;
   logic [MID_W-1:0]    mid_in, mid_out;

   // classify queue to back end
   logic                head_pop;
   lpc_pkg::work_type   head_work;
   logic [SLOT_W-1:0]   head_slot;

   // back end to result queue
   logic                out_push, out_full;
   lpc_pkg::rsp_type    out_item;
   logic [RSP_W-1:0]    out_vec, rsp_vec;

   assign full = mid_full;

   lpc_front #(
      .PIXELS (PIXELS),
      .SLOT_W (SLOT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .advance   (!mid_full),
      .work_push (mid_push),
      .work_data (front_work),
      .work_slot (front_slot)
   );

   assign mid_in = {front_slot, front_work};

   lpc_queue #(
      .WIDTH (MID_W),
      .DEPTH (lpc_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (head_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   assign head_work = lpc_pkg::work_type'(mid_out[WORK_W-1:0]);
   assign head_slot = mid_out[MID_W-1:WORK_W];

   lpc_back #(
      .PIXELS (PIXELS),
      .SLOT_W (SLOT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!mid_empty),
      .head_data  (head_work),
      .head_slot  (head_slot),
      .head_pop   (head_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_item)
   );

   assign out_vec = out_item;

   lpc_queue #(
      .WIDTH (RSP_W),
      .DEPTH (lpc_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_vec),
      .full      (out_full),
      .pop       (pop && !empty),
      .pop_data  (rsp_vec),
      .empty     (empty)
   );

   assign rsp_data = lpc_pkg::rsp_type'(rsp_vec);

`ifndef ASSERT_OFF
   // front only moves an item into the classify queue when there is room
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("classify queue pushed while full");

   // back end only takes an item that is really queued
   a_mid_no_underflow: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !mid_empty)
      else $error("classify queue popped while empty");

   // a finished pixel always finds a result slot
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue pushed while full");

   // no stale result survives reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");
`endif

endmodule

// ----- hdl/lpc_queue.sv -----
// small first-in first-out queue of register entries
module lpc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ----- hdl/lpc_front.sv -----
// front end: takes layer pixels, forms the alpha product and the buffer slot
module lpc_front #(
   parameter int PIXELS = 65536,
   parameter int SLOT_W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lpc_pkg::req_type    req_data,
   input  logic                advance,
   output logic                work_push,
   output lpc_pkg::work_type   work_data,
   output logic [SLOT_W-1:0]   work_slot
);

   localparam logic [32:0] SLOT_RECIP = 33'(64'h1_0000_0000 / PIXELS);
   localparam logic [16:0] SLOT_MOD   = 17'(PIXELS);
   localparam logic [24:0] SLOT_LIMIT = 25'(PIXELS);

   logic             v1_ff, v2_ff;
   lpc_pkg::req_type req1_ff, req2_ff;
   logic [15:0]      quot1_ff, quot1_in;
   logic [15:0]      prod1_ff, prod1_in;
   logic [15:0]      prod2_ff;
   logic [16:0]      qmul2_ff, qmul2_in;
   logic [48:0]      quot_prod;
   logic [16:0]      diff, diff_fix;

   // quotient estimate of index / PIXELS, low by at most one
   always_comb begin
      quot_prod = 49'(req_data.pixel_index) * 49'(SLOT_RECIP);
      quot1_in  = quot_prod[47:32];
      prod1_in  = 16'(req_data.src_alpha) * 16'(req_data.opacity);
      qmul2_in  = 17'(quot1_ff * SLOT_MOD);
   end

   always_comb begin
      diff     = {1'b0, req2_ff.pixel_index} - qmul2_ff;
      diff_fix = ({8'd0, diff} >= SLOT_LIMIT) ? (diff - SLOT_MOD) : diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= push;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req1_ff  <= req_data;
         quot1_ff <= quot1_in;
         prod1_ff <= prod1_in;
         req2_ff  <= req1_ff;
         prod2_ff <= prod1_ff;
         qmul2_ff <= qmul2_in;
      end
   end

   assign work_push = v2_ff && advance;
   assign work_data = '{req: req2_ff, alpha_prod: prod2_ff};
   assign work_slot = SLOT_W'(diff_fix);

endmodule

// ----- hdl/lpc_back.sv -----
// back end: read-modify-write of the accumulation buffer and the blend math
module lpc_back #(
   parameter int PIXELS = 65536,
   parameter int SLOT_W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  lpc_pkg::work_type   head_data,
   input  logic [SLOT_W-1:0]   head_slot,
   output logic                head_pop,
   input  logic                out_full,
   output logic                out_push,
   output lpc_pkg::rsp_type    out_data
);

   localparam int CH = lpc_pkg::CHANNELS;

   logic [31:0]       mem_ff [PIXELS];
   logic [31:0]       rd_data_ff;
   logic              wr_valid_ff;
   logic [SLOT_W-1:0] wr_slot_ff;
   logic [31:0]       wr_data_ff;

   logic              v1_ff, v2_ff, v3_ff;
   lpc_pkg::work_type item1_ff, item2_ff, item3_ff;
   logic [SLOT_W-1:0] slot1_ff, slot2_ff, slot3_ff;
   logic [31:0]       dest2_ff, dest3_ff;
   logic [CH-1:0][23:0] num2_ff, num2_in, num3_ff;
   logic [CH-1:0][7:0]  est3_ff, est3_in;

   logic              en, hazard, wr_en, fwd_hit;
   logic [31:0]       dest1;
   logic [CH-2:0][7:0] src1, src3;
   logic [CH-1:0][7:0] quot3, res3;

   // a dependent item waits until the older write is visible
   assign en       = !out_full;
   assign hazard   = !head_data.req.first_layer &&
                     ((v1_ff && (slot1_ff == head_slot)) ||
                      (v2_ff && (slot2_ff == head_slot)));
   assign head_pop = en && head_valid && !hazard;
   assign wr_en    = en && v3_ff;

   always_comb begin
      fwd_hit = wr_valid_ff && (wr_slot_ff == slot1_ff);
      if (item1_ff.req.first_layer) begin
         dest1 = '0;
      end else if (fwd_hit) begin
         dest1 = wr_data_ff;
      end else begin
         dest1 = rd_data_ff;
      end
      src1 = {item1_ff.req.src_blue, item1_ff.req.src_green, item1_ff.req.src_red};
      for (int i = 0; i < CH - 1; i++) begin
         num2_in[i] = lpc_pkg::chan_num(item1_ff.req.blend_mode, src1[i], dest1[8*i +: 8],
                                        item1_ff.alpha_prod);
      end
      num2_in[CH-1] = lpc_pkg::alpha_num(item1_ff.req.blend_mode, dest1[31:24],
                                         item1_ff.alpha_prod);
   end

   always_comb begin
      for (int i = 0; i < CH; i++) begin
         est3_in[i] = lpc_pkg::div_est(num2_ff[i]);
      end
   end

   always_comb begin
      src3 = {item3_ff.req.src_blue, item3_ff.req.src_green, item3_ff.req.src_red};
      for (int i = 0; i < CH; i++) begin
         quot3[i] = lpc_pkg::div_fix(num3_ff[i], est3_ff[i]);
      end
      for (int i = 0; i < CH - 1; i++) begin
         res3[i] = lpc_pkg::chan_result(item3_ff.req.blend_mode, quot3[i], src3[i],
                                        dest3_ff[8*i +: 8]);
      end
      res3[CH-1] = lpc_pkg::alpha_result(item3_ff.req.blend_mode, quot3[CH-1],
                                         dest3_ff[31:24]);
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rd_data_ff <= mem_ff[head_slot];
      end
      if (wr_en) begin
         mem_ff[slot3_ff] <= res3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            v1_ff <= head_pop;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         if (wr_en) begin
            wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= head_data;
         slot1_ff <= head_slot;
         item2_ff <= item1_ff;
         slot2_ff <= slot1_ff;
         dest2_ff <= dest1;
         num2_ff  <= num2_in;
         item3_ff <= item2_ff;
         slot3_ff <= slot2_ff;
         dest3_ff <= dest2_ff;
         num3_ff  <= num2_ff;
         est3_ff  <= est3_in;
      end
      if (wr_en) begin
         wr_slot_ff <= slot3_ff;
         wr_data_ff <= res3;
      end
   end

   assign out_push = wr_en;
   assign out_data = '{out_index: item3_ff.req.pixel_index,
                       out_red:   res3[0],
                       out_green: res3[1],
                       out_blue:  res3[2],
                       out_alpha: res3[CH-1]};

endmodule
